// ----- hdl/nfpa_pkg.sv -----
// Shared widths, codes and controller/datapath interface types for the page allocator.
package nfpa_pkg;

   // Fixed field widths of the item, result and register ports.
   localparam int INDEX_WIDTH     = 10;
   localparam int ADDR_WIDTH      = 48;
   localparam int SHIFT_WIDTH     = 5;
   localparam int ENTRY_WIDTH     = 7;
   localparam int MODE_WIDTH      = 2;
   localparam int STATUS_WIDTH    = 2;
   localparam int CSR_INDEX_WIDTH = 2;

   // Defaults for the top-level parameters.
   localparam int DEFAULT_PAGES       = 1024;
   localparam int DEFAULT_COUNT_WIDTH = 8;

   // Item modes.
   localparam logic [MODE_WIDTH-1:0] MODE_INIT  = 2'd0;
   localparam logic [MODE_WIDTH-1:0] MODE_ALLOC = 2'd1;
   localparam logic [MODE_WIDTH-1:0] MODE_FREE  = 2'd2;

   // Result status codes.
   localparam logic [STATUS_WIDTH-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_NO_FREE = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_UNUSED  = 2'd2;
   localparam logic [STATUS_WIDTH-1:0] STATUS_RANGE   = 2'd3;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_START = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_REGION_END   = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PAGE_SHIFT   = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ENTRY_BYTES  = 2'd3;

   // Register reset values.
   localparam logic [SHIFT_WIDTH-1:0] PAGE_SHIFT_RESET  = 5'd12;
   localparam logic [ENTRY_WIDTH-1:0] ENTRY_BYTES_RESET = 7'd16;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load_req;
      logic calc_span;
      logic calc_pages;
      logic calc_table;
      logic calc_used;
      logic fill_write;
      logic init_done;
      logic scan_begin;
      logic scan_step;
      logic grant;
      logic no_free;
      logic free_read;
      logic free_done;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic fill_done;
      logic scan_hit;
      logic scan_exhausted;
   } stat_type;

endpackage

// ----- hdl/nfpa_ctrl.sv -----
// Controller state machine that sequences init, alloc and free items.
module nfpa_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [nfpa_pkg::MODE_WIDTH-1:0]     req_mode,
   output logic                                busy,
   output nfpa_pkg::cmd_type                   cmd_o,
   input  nfpa_pkg::stat_type                  stat_i
);

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_INIT_SPAN  = 9'b000000010,
      ST_INIT_PAGES = 9'b000000100,
      ST_INIT_TABLE = 9'b000001000,
      ST_INIT_USED  = 9'b000010000,
      ST_INIT_FILL  = 9'b000100000,
      ST_SCAN       = 9'b001000000,
      ST_FREE_READ  = 9'b010000000,
      ST_FREE_CHECK = 9'b100000000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and command decode.
   always_comb begin
      cmd_o    = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_o.load_req = 1'b1;
               unique case (req_mode)
                  nfpa_pkg::MODE_INIT: begin
                     state_in = ST_INIT_SPAN;
                  end
                  nfpa_pkg::MODE_ALLOC: begin
                     cmd_o.scan_begin = 1'b1;
                     state_in         = ST_SCAN;
                  end
                  nfpa_pkg::MODE_FREE: begin
                     state_in = ST_FREE_READ;
                  end
                  default: begin
                     // The unassigned mode is taken and dropped without a result.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_INIT_SPAN: begin
            cmd_o.calc_span = 1'b1;
            state_in        = ST_INIT_PAGES;
         end
         ST_INIT_PAGES: begin
            cmd_o.calc_pages = 1'b1;
            state_in         = ST_INIT_TABLE;
         end
         ST_INIT_TABLE: begin
            cmd_o.calc_table = 1'b1;
            state_in         = ST_INIT_USED;
         end
         ST_INIT_USED: begin
            cmd_o.calc_used = 1'b1;
            state_in        = ST_INIT_FILL;
         end
         ST_INIT_FILL: begin
            if (stat_i.fill_done) begin
               cmd_o.init_done = 1'b1;
               state_in        = ST_IDLE;
            end else begin
               cmd_o.fill_write = 1'b1;
            end
         end
         ST_SCAN: begin
            priority if (stat_i.scan_hit) begin
               cmd_o.grant = 1'b1;
               state_in    = ST_IDLE;
            end else if (stat_i.scan_exhausted) begin
               cmd_o.no_free = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd_o.scan_step = 1'b1;
            end
         end
         ST_FREE_READ: begin
            cmd_o.free_read = 1'b1;
            state_in        = ST_FREE_CHECK;
         end
         ST_FREE_CHECK: begin
            cmd_o.free_done = 1'b1;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

// ----- hdl/nfpa_datapath.sv -----
// Datapath: configuration registers, use-count table, scan pointers and result registers.
module nfpa_datapath #(
   parameter int PAGES       = nfpa_pkg::DEFAULT_PAGES,
   parameter int COUNT_WIDTH = nfpa_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    csr_we,
   input  logic [nfpa_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [nfpa_pkg::ADDR_WIDTH-1:0]         csr_wdata,
   input  logic [nfpa_pkg::INDEX_WIDTH-1:0]        req_page_index,
   input  nfpa_pkg::cmd_type                       cmd_i,
   output nfpa_pkg::stat_type                      stat_o,
   output logic                                    rsp_valid,
   output logic [nfpa_pkg::INDEX_WIDTH-1:0]        rsp_granted_index,
   output logic [nfpa_pkg::ADDR_WIDTH-1:0]         rsp_granted_address,
   output logic [nfpa_pkg::STATUS_WIDTH-1:0]       rsp_status
);

   localparam int PW    = $clog2(PAGES);
   localparam int NW    = $clog2(PAGES + 1);
   localparam int TW    = NW + nfpa_pkg::ENTRY_WIDTH;
   localparam int AW    = (PW > nfpa_pkg::INDEX_WIDTH) ? PW : nfpa_pkg::INDEX_WIDTH;
   localparam int CMP_W = (NW > nfpa_pkg::INDEX_WIDTH) ? NW : nfpa_pkg::INDEX_WIDTH;
   localparam int AD_W  = nfpa_pkg::ADDR_WIDTH;

   // Configuration registers.
   logic [AD_W-1:0]                      region_start_ff;
   logic [AD_W-1:0]                      region_end_ff;
   logic [nfpa_pkg::SHIFT_WIDTH-1:0]     page_shift_ff;
   logic [nfpa_pkg::ENTRY_WIDTH-1:0]     entry_bytes_ff;

   // Allocator state.
   logic [NW-1:0]                        pages_ff;
   logic [PW-1:0]                        ptr_ff;
   logic [PW-1:0]                        ptr_in;
   logic                                 ptr_we;

   // Init arithmetic.
   logic [AD_W-1:0]                      span_ff;
   logic [AD_W-1:0]                      span_shifted;
   logic [TW-1:0]                        table_ff;
   logic [TW-1:0]                        used_raw;
   logic [NW-1:0]                        used_ff;
   logic [NW-1:0]                        fill_idx_ff;

   // Scan pipeline.
   logic [PW-1:0]                        issue_idx_ff;
   logic [NW-1:0]                        issue_cnt_ff;
   logic [PW-1:0]                        probe_idx_ff;
   logic                                 probe_valid_ff;
   logic [PW-1:0]                        scan_start;
   logic [PW-1:0]                        issue_next;
   logic [PW-1:0]                        probe_next;
   logic [NW-1:0]                        issue_inc;
   logic [NW-1:0]                        probe_inc;
   logic                                 issue_go;

   // Request and table access.
   logic [nfpa_pkg::INDEX_WIDTH-1:0]     req_idx_ff;
   logic                                 free_in_range;
   logic [COUNT_WIDTH-1:0]               count_mem [PAGES];
   logic [COUNT_WIDTH-1:0]               rd_data_ff;
   logic                                 rd_en;
   logic [PW-1:0]                        rd_addr;
   logic                                 wr_en;
   logic [PW-1:0]                        wr_addr;
   logic [COUNT_WIDTH-1:0]               wr_data;

   // Result registers.
   logic                                 rsp_valid_ff;
   logic [nfpa_pkg::INDEX_WIDTH-1:0]     rsp_idx_ff;
   logic [nfpa_pkg::INDEX_WIDTH-1:0]     rsp_idx_in;
   logic [AD_W-1:0]                      rsp_addr_ff;
   logic [AD_W-1:0]                      rsp_addr_in;
   logic [nfpa_pkg::STATUS_WIDTH-1:0]    rsp_stat_ff;
   logic [nfpa_pkg::STATUS_WIDTH-1:0]    rsp_stat_in;
   logic [AW-1:0]                        rsp_aidx;
   logic                                 rsp_zero_addr;
   logic                                 rsp_fire;

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         region_start_ff <= '0;
         region_end_ff   <= '0;
         page_shift_ff   <= nfpa_pkg::PAGE_SHIFT_RESET;
         entry_bytes_ff  <= nfpa_pkg::ENTRY_BYTES_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            nfpa_pkg::CSR_REGION_START: region_start_ff <= csr_wdata;
            nfpa_pkg::CSR_REGION_END:   region_end_ff   <= csr_wdata;
            nfpa_pkg::CSR_PAGE_SHIFT:
               page_shift_ff <= csr_wdata[nfpa_pkg::SHIFT_WIDTH-1:0];
            nfpa_pkg::CSR_ENTRY_BYTES:
               entry_bytes_ff <= csr_wdata[nfpa_pkg::ENTRY_WIDTH-1:0];
            default: begin
            end
         endcase
      end
   end

   // Init arithmetic: page count, table size, then pages held by the table.
   assign span_shifted = span_ff >> page_shift_ff;
   assign used_raw     = (table_ff >> page_shift_ff)
                       + TW'(|(table_ff & ~({TW{1'b1}} << page_shift_ff)));

   always_ff @(posedge clock) begin
      if (cmd_i.calc_span) begin
         span_ff <= (region_end_ff > region_start_ff) ? (region_end_ff - region_start_ff)
                                                     : '0;
      end
      if (cmd_i.calc_table) begin
         table_ff <= TW'(pages_ff) * TW'(entry_bytes_ff);
      end
      if (cmd_i.calc_used) begin
         used_ff <= (used_raw > TW'(pages_ff)) ? pages_ff : NW'(used_raw);
      end
   end

   // Page count and fill counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         pages_ff    <= '0;
         fill_idx_ff <= '0;
      end else begin
         if (cmd_i.calc_pages) begin
            pages_ff <= (span_shifted > AD_W'(PAGES)) ? NW'(PAGES) : NW'(span_shifted);
         end
         if (cmd_i.calc_used) begin
            fill_idx_ff <= '0;
         end else if (cmd_i.fill_write) begin
            fill_idx_ff <= fill_idx_ff + NW'(1);
         end
      end
   end

   // Scan start and wrap-around successors.
   assign scan_start = (NW'(ptr_ff) >= pages_ff) ? '0 : ptr_ff;
   assign issue_inc  = NW'(issue_idx_ff) + NW'(1);
   assign probe_inc  = NW'(probe_idx_ff) + NW'(1);
   assign issue_next = (issue_inc == pages_ff) ? '0 : issue_inc[PW-1:0];
   assign probe_next = (probe_inc == pages_ff) ? '0 : probe_inc[PW-1:0];
   assign issue_go   = cmd_i.scan_step && (issue_cnt_ff != pages_ff);

   // Scan pipeline: one table read issued per cycle while the scan steps, checked in the next cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         issue_cnt_ff   <= '0;
         probe_valid_ff <= 1'b0;
      end else begin
         if (cmd_i.scan_begin) begin
            issue_cnt_ff <= '0;
         end else if (issue_go) begin
            issue_cnt_ff <= issue_cnt_ff + NW'(1);
         end
         probe_valid_ff <= issue_go;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_i.scan_begin) begin
         issue_idx_ff <= scan_start;
      end else if (issue_go) begin
         issue_idx_ff <= issue_next;
      end
      if (issue_go) begin
         probe_idx_ff <= issue_idx_ff;
      end
      if (cmd_i.load_req) begin
         req_idx_ff <= req_page_index;
      end
   end

   assign stat_o.fill_done      = (fill_idx_ff == pages_ff);
   assign stat_o.scan_hit       = probe_valid_ff && (rd_data_ff == '0);
   assign stat_o.scan_exhausted = (issue_cnt_ff == pages_ff) && !stat_o.scan_hit;

   // Search pointer moves past each granted page.
   assign ptr_we = cmd_i.grant;
   assign ptr_in = probe_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else if (ptr_we) begin
         ptr_ff <= ptr_in;
      end
   end

   // Table port selection.
   assign free_in_range = (CMP_W'(req_idx_ff) < CMP_W'(pages_ff));
   assign rd_en         = cmd_i.free_read || issue_go;
   assign rd_addr       = cmd_i.free_read ? PW'(req_idx_ff) : issue_idx_ff;

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = '0;
      wr_data = '0;
      priority if (cmd_i.fill_write) begin
         wr_en   = 1'b1;
         wr_addr = fill_idx_ff[PW-1:0];
         wr_data = (fill_idx_ff < used_ff) ? COUNT_WIDTH'(1) : '0;
      end else if (cmd_i.grant) begin
         wr_en   = 1'b1;
         wr_addr = probe_idx_ff;
         wr_data = COUNT_WIDTH'(1);
      end else if (cmd_i.free_done && free_in_range && (rd_data_ff != '0)) begin
         wr_en   = 1'b1;
         wr_addr = PW'(req_idx_ff);
         wr_data = rd_data_ff - COUNT_WIDTH'(1);
      end else begin
         wr_en = 1'b0;
      end
   end

   // Use-count table.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         count_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= count_mem[rd_addr];
      end
   end

   // Result selection.
   always_comb begin
      rsp_fire      = 1'b0;
      rsp_idx_in    = '0;
      rsp_aidx      = '0;
      rsp_stat_in   = nfpa_pkg::STATUS_OK;
      rsp_zero_addr = 1'b0;
      priority if (cmd_i.init_done) begin
         rsp_fire = 1'b1;
      end else if (cmd_i.grant) begin
         rsp_fire   = 1'b1;
         rsp_idx_in = nfpa_pkg::INDEX_WIDTH'(probe_idx_ff);
         rsp_aidx   = AW'(probe_idx_ff);
      end else if (cmd_i.no_free) begin
         rsp_fire      = 1'b1;
         rsp_stat_in   = nfpa_pkg::STATUS_NO_FREE;
         rsp_zero_addr = 1'b1;
      end else if (cmd_i.free_done) begin
         rsp_fire   = 1'b1;
         rsp_idx_in = req_idx_ff;
         rsp_aidx   = AW'(req_idx_ff);
         priority if (!free_in_range) begin
            rsp_stat_in = nfpa_pkg::STATUS_RANGE;
         end else if (rd_data_ff == '0) begin
            rsp_stat_in = nfpa_pkg::STATUS_UNUSED;
         end else begin
            rsp_stat_in = nfpa_pkg::STATUS_OK;
         end
      end else begin
         rsp_fire = 1'b0;
      end
   end

   assign rsp_addr_in = rsp_zero_addr ? '0
                      : region_start_ff + (AD_W'(rsp_aidx) << page_shift_ff);

   // Result registers: the strobe lasts one cycle.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_fire;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_fire) begin
         rsp_idx_ff  <= rsp_idx_in;
         rsp_addr_ff <= rsp_addr_in;
         rsp_stat_ff <= rsp_stat_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_granted_index   = rsp_idx_ff;
   assign rsp_granted_address = rsp_addr_ff;
   assign rsp_status          = rsp_stat_ff;

   // Every result comes from a finishing step that leaves the item, so strobes never touch.
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   // The scan never issues more probes than there are pages.
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_i.scan_step |-> (issue_cnt_ff <= pages_ff))
      else $error("scan issued past the page count");

   // The table fill stays inside the managed pages.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd_i.fill_write |-> (fill_idx_ff < pages_ff))
      else $error("table fill ran past the page count");

   // A grant takes a page whose count was read as zero from a live probe.
   a_grant_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.grant |-> (probe_valid_ff && (rd_data_ff == '0)))
      else $error("grant of a page in use");

endmodule

// ----- hdl/next_fit_page_allocator_top.sv -----
// Top level of the next-fit page frame allocator.
//
// Usage: set region_start, region_end, page_shift and entry_bytes on the csr_ port while
// the block is idle, then send an init item (req_mode 0) before any alloc or free item.
// An item is taken on a rising edge with start high and busy low; busy stays high until
// its one result has been loaded. The result appears on the rsp_ ports for one cycle,
// marked by rsp_valid; the receiver cannot stall it, and busy falls in that same cycle.
// Steps from the accepting edge to the strobe cycle:
//   init  : span, page count, table size, used pages, then one table entry written a cycle.
//   alloc : the scan probes pages until a free one is found, at most the page count;
//           the scan reads one use count per cycle from the read port of the count table.
//   free  : read count, check and write back.
// Mode 3 is accepted and gives no result; the block is free again the next cycle.
// Reset restores the register defaults and sets the page count and search pointer to
// zero, so no table entry is used before an init writes it; no clearing pass runs.
module next_fit_page_allocator_top #(
   parameter int PAGES       = nfpa_pkg::DEFAULT_PAGES,
   parameter int COUNT_WIDTH = nfpa_pkg::DEFAULT_COUNT_WIDTH
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   output logic                                    busy,
   input  logic [nfpa_pkg::MODE_WIDTH-1:0]         req_mode,
   input  logic [nfpa_pkg::INDEX_WIDTH-1:0]        req_page_index,
   output logic                                    rsp_valid,
   output logic [nfpa_pkg::INDEX_WIDTH-1:0]        rsp_granted_index,
   output logic [nfpa_pkg::ADDR_WIDTH-1:0]         rsp_granted_address,
   output logic [nfpa_pkg::STATUS_WIDTH-1:0]       rsp_status,
   input  logic                                    csr_we,
   input  logic [nfpa_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [nfpa_pkg::ADDR_WIDTH-1:0]         csr_wdata
);

   nfpa_pkg::cmd_type  cmd;
   nfpa_pkg::stat_type stat;

   // Sequencer.
   nfpa_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_mode (req_mode),
      .busy     (busy),
      .cmd_o    (cmd),
      .stat_i   (stat)
   );

   // Table, arithmetic and result registers.
   nfpa_datapath #(
      .PAGES       (PAGES),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .csr_we              (csr_we),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .req_page_index      (req_page_index),
      .cmd_i               (cmd),
      .stat_o              (stat),
      .rsp_valid           (rsp_valid),
      .rsp_granted_index   (rsp_granted_index),
      .rsp_granted_address (rsp_granted_address),
      .rsp_status          (rsp_status)
   );

endmodule
